/* design/tcs_pkg.sv */
package tcs_pkg;

  localparam int CAPACITY = 16;
  localparam int MAX_OUT = 16;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int NOUT_W = $clog2(MAX_OUT + 1);
  localparam int NPS_W = 30;
  localparam logic [NPS_W-1:0] NPS_RESET = 30'd100000;
  localparam int MS_W = 15;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;
  localparam int DIVD_W = 35;
  localparam int DCNT_W = $clog2(DIVD_W);
  localparam int CNT_W = 32;

  localparam logic [1:0] ST_REGISTERED = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUE = 2'd3;

  localparam logic [1:0] KIND_ANALOG_OUT = 2'd0;
  localparam logic [1:0] KIND_ANALOG_IN = 2'd1;
  localparam logic [1:0] KIND_CALLBACK = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG,
    S_DIV,
    S_SUM,
    S_SCAN,
    S_PICK,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic commit;
    logic set_err;
    logic scan_step;
    logic take;
    logic next_group;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic bad_kind;
    logic div_last;
    logic scan_last;
    logic found;
    logic group;
    logic n_last;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

/* design/tcs_ctrl.sv */
module tcs_ctrl
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t sts,
  output logic       in_stall,
  output ctrl_cmd_t  ctl,
  output state_t     state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_REG;
        end
      end
      S_REG: begin
        if (sts.is_tick) begin
          state_next = S_SCAN;
        end else if (sts.full || sts.bad_kind) begin
          ctl.set_err = 1'b1;
          state_next = S_FINAL;
        end else begin
          ctl.start_div = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        ctl.commit = 1'b1;
        state_next = S_FINAL;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (sts.found) begin
          // the held result goes out as not-last before the new one replaces it
          if (!sts.pend_valid || sts.out_free) begin
            ctl.take = 1'b1;
            state_next = sts.n_last ? S_FINAL : S_SCAN;
          end
        end else if (!sts.group) begin
          ctl.next_group = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          ctl.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/tcs_datapath.sv */
module tcs_datapath
  import tcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         ctl,
  output dp_status_t        sts,
  input  logic              cmd,
  input  logic [1:0]        command_kind,
  input  logic signed [15:0] delay_ms,
  input  logic [31:0]       payload,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [NPS_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [3:0]        slot,
  output logic [1:0]        due_kind,
  output logic [31:0]       due_payload,
  output logic              last_of_run
);

  logic [CAPACITY-1:0] busy;
  logic [CNT_W-1:0]    due_mem [CAPACITY];
  logic [1:0]          kind_mem [CAPACITY];
  logic [31:0]         pay_mem [CAPACITY];
  logic [CNT_W-1:0]    scan_counter;
  logic [NPS_W-1:0]    scan_period_ns;

  logic                in_cmd;
  logic [1:0]          in_kind;
  logic [15:0]         in_delay;
  logic [31:0]         in_payload;

  logic [DIVD_W-1:0]   quo;
  logic [NPS_W-1:0]    rem;
  logic [DCNT_W-1:0]   div_cnt;

  logic [SLOT_W-1:0]   idx;
  logic                group;
  logic [NOUT_W-1:0]   n_out;
  logic                found;
  logic [SLOT_W-1:0]   best_slot;
  logic [CNT_W-1:0]    best_due;
  logic [1:0]          best_kind;
  logic [31:0]         best_payload;

  logic                pend_valid;
  logic [1:0]          pend_status;
  logic [SLOT_W-1:0]   pend_slot;
  logic [1:0]          pend_kind;
  logic [31:0]         pend_payload;

  logic [SLOT_W-1:0]   free_slot;
  logic                full;
  logic [MS_W-1:0]     ms;
  logic [DIVD_W-1:0]   product;
  logic [NPS_W-1:0]    divisor;
  logic [NPS_W:0]      rem_sh;
  logic [NPS_W:0]      rem_sub;
  logic [DIVD_W:0]     due_sum;
  logic [CNT_W-1:0]    due_sat;
  logic                hit;
  logic                out_free;
  logic                emit;

  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign full = &busy;
  assign ms = in_delay[15] ? '0 : in_delay[MS_W-1:0];
  assign product = DIVD_W'(ms) * DIVD_W'(NS_PER_MS);
  assign divisor = (scan_period_ns == '0) ? NPS_W'(1) : scan_period_ns;

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem, quo[DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  assign due_sum = (DIVD_W + 1)'(scan_counter) + (DIVD_W + 1)'(quo);
  assign due_sat = (due_sum[DIVD_W:CNT_W] != '0) ? '1 : due_sum[CNT_W-1:0];

  assign hit = busy[idx] && (due_mem[idx] <= scan_counter) &&
               ((kind_mem[idx] == KIND_CALLBACK) == group) &&
               (!found || (due_mem[idx] < best_due));

  assign out_free = !out_valid || !out_stall;
  assign emit = (ctl.take && pend_valid) || ctl.emit_last;

  assign sts.is_tick = (in_cmd == CMD_TICK);
  assign sts.full = full;
  assign sts.bad_kind = (in_kind == KIND_UNKNOWN);
  assign sts.div_last = (div_cnt == DCNT_W'(DIVD_W - 1));
  assign sts.scan_last = (idx == SLOT_W'(CAPACITY - 1));
  assign sts.found = found;
  assign sts.group = group;
  assign sts.n_last = (n_out == NOUT_W'(MAX_OUT - 1));
  assign sts.pend_valid = pend_valid;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period_ns <= NPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scan_period_ns <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_cmd <= cmd;
      in_kind <= command_kind;
      in_delay <= delay_ms;
      in_payload <= payload;
    end
    if (ctl.start_div) begin
      quo <= product;
      rem <= '0;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      if (!rem_sub[NPS_W]) begin
        rem <= rem_sub[NPS_W-1:0];
      end else begin
        rem <= rem_sh[NPS_W-1:0];
      end
      quo <= {quo[DIVD_W-2:0], !rem_sub[NPS_W]};
      div_cnt <= div_cnt + DCNT_W'(1);
    end
    if (ctl.commit) begin
      due_mem[free_slot] <= due_sat;
      kind_mem[free_slot] <= in_kind;
      pay_mem[free_slot] <= in_payload;
    end
    if (ctl.scan_step && hit) begin
      best_slot <= idx;
      best_due <= due_mem[idx];
      best_kind <= kind_mem[idx];
      best_payload <= pay_mem[idx];
    end
    if (ctl.set_err) begin
      pend_status <= full ? ST_FULL : ST_BAD_KIND;
      pend_slot <= '0;
      pend_kind <= '0;
      pend_payload <= '0;
    end else if (ctl.commit) begin
      pend_status <= ST_REGISTERED;
      pend_slot <= free_slot;
      pend_kind <= '0;
      pend_payload <= '0;
    end else if (ctl.take) begin
      pend_status <= ST_DUE;
      pend_slot <= best_slot;
      pend_kind <= best_kind;
      pend_payload <= best_payload;
    end
    if (emit) begin
      status <= pend_status;
      slot <= 4'(pend_slot);
      due_kind <= pend_kind;
      due_payload <= pend_payload;
      last_of_run <= ctl.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      scan_counter <= '0;
      idx <= '0;
      group <= 1'b0;
      n_out <= '0;
      found <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        if (cmd == CMD_TICK && scan_counter != '1) begin
          scan_counter <= scan_counter + CNT_W'(1);
        end
        idx <= '0;
        group <= 1'b0;
        n_out <= '0;
        found <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (ctl.commit) begin
        busy[free_slot] <= 1'b1;
      end
      if (ctl.commit || ctl.set_err) begin
        pend_valid <= 1'b1;
      end
      if (ctl.scan_step) begin
        idx <= idx + SLOT_W'(1);
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (ctl.take) begin
        busy[best_slot] <= 1'b0;
        n_out <= n_out + NOUT_W'(1);
        pend_valid <= 1'b1;
        found <= 1'b0;
        idx <= '0;
      end
      if (ctl.next_group) begin
        group <= 1'b1;
        idx <= '0;
      end
      if (ctl.emit_last) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/timed_command_scheduler_core.sv */
// channel | signals                                                  | flow
// in      | in_valid, in_stall, cmd, command_kind, delay_ms, payload | into block
// out     | out_valid, out_stall, status, slot, due_kind, due_payload,  | out of block
//         | last_of_run                                              |
// cfg     | cfg_valid, cfg_ready, cfg_data                           | into block
//
// a registration runs the bit-serial divider (35 steps) unless the table is full
// or the kind is bad; a tick walks the table once per result and once per group
// that ends the search
// reset clears the busy flags, the scan counter and the divisor (back to 100000)
// a stalled output holds the walk until the waiting transaction is taken
module timed_command_scheduler_core
  import tcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [1:0]         command_kind,
  input  logic signed [15:0] delay_ms,
  input  logic [31:0]        payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [3:0]         slot,
  output logic [1:0]         due_kind,
  output logic [31:0]        due_payload,
  output logic               last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [NPS_W-1:0]   cfg_data
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;
  state_t     state;

  assign cfg_ready = 1'b1;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl),
    .state    (state)
  );

  tcs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .command_kind (command_kind),
    .delay_ms     (delay_ms),
    .payload      (payload),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot         (slot),
    .due_kind     (due_kind),
    .due_payload  (due_payload),
    .last_of_run  (last_of_run)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a transaction");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sts.pend_valid)
    else $error("held result left behind in idle");

  a_take_needs_found: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> sts.found && (!sts.pend_valid || sts.out_free))
    else $error("take without a due entry or a free output");
`endif

endmodule

/* sim/testbench.sv */
module testbench;
  import tcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [1:0]  due_kind;
    logic [31:0] due_payload;
    logic        last_of_run;
  } sched_result_t;

  class sched_scoreboard;
    bit          busy[CAPACITY];
    logic [31:0] due_at[CAPACITY];
    logic [1:0]  kind_of[CAPACITY];
    logic [31:0] data_of[CAPACITY];
    logic [31:0] scan_count;
    logic [29:0] scan_ns;
    sched_result_t pending_results[$];
    int errors;

    function void clear();
      foreach (busy[i]) busy[i] = 0;
      scan_count = 0;
      scan_ns = NPS_RESET;
      pending_results.delete();
      errors = 0;
    endfunction

    function int lowest_due(bit callbacks);
      int best;
      best = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (!busy[i] || due_at[i] > scan_count) continue;
        if ((kind_of[i] == KIND_CALLBACK) != callbacks) continue;
        if (best < 0 || due_at[i] < due_at[best]) best = i;
      end
      return best;
    endfunction

    function void note_item(logic c, logic [1:0] k, logic signed [15:0] d, logic [31:0] p);
      sched_result_t r;
      int free_slot, n, s;
      logic [63:0] ms, q, due;
      logic [31:0] dv;
      if (c == CMD_REGISTER) begin
        r = '{ST_REGISTERED, 0, 0, 0, 1};
        free_slot = -1;
        for (int i = CAPACITY - 1; i >= 0; i--) if (!busy[i]) free_slot = i;
        if (free_slot < 0) r.status = ST_FULL;
        else if (k == KIND_UNKNOWN) r.status = ST_BAD_KIND;
        else begin
          ms = d[15] ? 64'd0 : 64'(d);
          dv = (scan_ns == 0) ? 32'd1 : 32'(scan_ns);
          q = ms * 64'd1000000 / 64'(dv);
          due = 64'(scan_count) + q;
          if (due > 64'(CNT_MAX)) due = 64'(CNT_MAX);
          busy[free_slot] = 1;
          due_at[free_slot] = due[31:0];
          kind_of[free_slot] = k;
          data_of[free_slot] = p;
          r.slot = free_slot[3:0];
        end
        pending_results.push_back(r);
      end else begin
        n = 0;
        if (scan_count != CNT_MAX) scan_count++;
        for (int g = 0; g < 2; g++) begin
          while (n < MAX_OUT) begin
            s = lowest_due(g == 1);
            if (s < 0) break;
            r = '{ST_DUE, s[3:0], kind_of[s], data_of[s], 0};
            busy[s] = 0;
            pending_results.push_back(r);
            n++;
          end
        end
        if (n > 0) pending_results[$].last_of_run = 1;
      end
    endfunction

    function void check_result(sched_result_t a);
      sched_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d slot=%0d", a.status, a.slot);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (a.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, a.status); errors++;
      end
      if (a.slot !== e.slot) begin
        $error("slot expected %0d actual %0d", e.slot, a.slot); errors++;
      end
      if (a.due_kind !== e.due_kind) begin
        $error("due_kind expected %0d actual %0d", e.due_kind, a.due_kind); errors++;
      end
      if (a.due_payload !== e.due_payload) begin
        $error("due_payload expected %h actual %h", e.due_payload, a.due_payload); errors++;
      end
      if (a.last_of_run !== e.last_of_run) begin
        $error("last_of_run expected %0d actual %0d", e.last_of_run, a.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic cmd = 0;
  logic [1:0] command_kind = 0;
  logic signed [15:0] delay_ms = 0;
  logic [31:0] payload = 0;
  logic out_valid, out_stall = 0;
  logic [1:0] status, due_kind;
  logic [3:0] slot;
  logic [31:0] due_payload;
  logic last_of_run;
  logic cfg_valid = 0, cfg_ready;
  logic [NPS_W-1:0] cfg_data = 0;

  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;
  sched_scoreboard board;

  timed_command_scheduler_core dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall)
        board.check_result('{status, slot, due_kind, due_payload, last_of_run});
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays up after a transaction until the next item or an idle cycle
  task automatic send_item(logic c, logic [1:0] k, logic signed [15:0] d, logic [31:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    command_kind <= k;
    delay_ms <= d;
    payload <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(c, k, d, p);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_scan_ns(logic [29:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    board.scan_ns = v;
  endtask

  task automatic tick();
    send_item(CMD_TICK, 2'($urandom), 16'($urandom), $urandom);
  endtask

  // mostly registrations with short delays, enough ticks to keep the table cycling
  task automatic random_phase(int items, int idle, int stall);
    logic signed [15:0] d;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(9))
        0: d = 16'($urandom);
        1: d = -$signed(16'($urandom_range(32768)));
        default: d = 16'($urandom_range(3));
      endcase
      if ($urandom_range(99) < 45) tick();
      else send_item(CMD_REGISTER,
                     ($urandom_range(9) == 0) ? KIND_UNKNOWN : 2'($urandom_range(2)),
                     d, $urandom);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: scan ns = 1 ms so each delay ms is one tick
    write_scan_ns(30'd1000000);
    send_item(CMD_REGISTER, KIND_ANALOG_OUT, 16'sd0, 32'hFFFF_FFFF);
    send_item(CMD_REGISTER, KIND_ANALOG_IN, 16'sh8000, 32'h0);
    send_item(CMD_REGISTER, KIND_CALLBACK, 16'sd1, 32'hA5A5_5A5A);
    send_item(CMD_REGISTER, KIND_UNKNOWN, 16'sd1, 32'h1234);
    send_item(CMD_REGISTER, KIND_ANALOG_IN, 16'sd2, 32'h5A5A_A5A5);
    tick();
    tick();
    tick();
    // full table, then a tick releasing all sixteen at once
    for (int i = 0; i < CAPACITY; i++)
      send_item(CMD_REGISTER, 2'(i % 3), 16'sd1, 32'(i) << 27 | 32'(i));
    send_item(CMD_REGISTER, KIND_ANALOG_OUT, 16'sd1, 32'h1);
    send_item(CMD_REGISTER, KIND_UNKNOWN, 16'sd1, 32'h1);
    tick();
    tick();
    tick();

    // zero divisor and saturating due scan, parked in slot 0 forever
    write_scan_ns(30'd0);
    send_item(CMD_REGISTER, KIND_ANALOG_OUT, 16'sd32767, 32'hDEAD_BEEF);
    tick();

    write_scan_ns(30'd1000000);
    random_phase(95, 0, 0);
    write_scan_ns(30'd250000);
    random_phase(95, 60, 0);
    write_scan_ns(30'h3FFF_FFFF);
    random_phase(95, 0, 60);
    write_scan_ns(30'd1);
    // tiny divisor: any positive delay lands at least a million ticks out; only zero or negative delays come due
    random_phase(40, 36, 36);
    write_scan_ns(30'd100000);
    random_phase(55, 36, 36);

    drain();
    if (board.errors == 0 && board.pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

/* timed_command_scheduler_core.f */
design/tcs_pkg.sv
design/tcs_ctrl.sv
design/tcs_datapath.sv
design/timed_command_scheduler_core.sv
sim/testbench.sv
